### hw/rtl/lcg_pkg.sv
// Shared types, constants and helpers for the line cell generator.
// Used by lcg_step_unit and bresenham_line_cell_generator; depends on nothing.

package lcg_pkg;

   localparam int MAX_SIDE = 63;
   localparam int COORD_W  = $clog2(MAX_SIDE + 1);
   localparam int IDX_W    = 2 * COORD_W;
   localparam int CHAR_W   = 8;
   localparam int PT_W     = 8;

   localparam logic [1:0] DIR_NONE = 2'b00;
   localparam logic [1:0] DIR_POS  = 2'b01;
   localparam logic [1:0] DIR_NEG  = 2'b11;

   localparam logic CSR_ROW_WIDTH = 1'b0;
   localparam logic CSR_ROW_COUNT = 1'b1;

   typedef struct packed {
      logic [1:0] str_y;
      logic [1:0] str_x;
      logic [1:0] diag_y;
      logic [1:0] diag_x;
   } dirs_type;

   typedef struct packed {
      logic [COORD_W-1:0] longest;
      logic [COORD_W-1:0] shortest;
      dirs_type           dirs;
   } line_type;

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] num;
      logic [IDX_W-1:0]   idx;
   } walk_type;

   function automatic logic cell_fits(input logic [IDX_W-1:0] idx,
                                      input logic [IDX_W-1:0] cells);
      return ({1'b0, idx} + {{IDX_W{1'b0}}, 1'b1}) < {1'b0, cells};
   endfunction

endpackage

### hw/rtl/lcg_step_unit.sv
// Shared step unit: advances one Bresenham point, its error term and cell index.
// Depends on lcg_pkg.

module lcg_step_unit (
   input  lcg_pkg::walk_type               cur_i,
   input  lcg_pkg::line_type               line_i,
   input  logic [lcg_pkg::COORD_W-1:0]     row_width_i,
   input  logic [lcg_pkg::IDX_W-1:0]       cells_i,
   output lcg_pkg::walk_type               nxt_o,
   output logic                            fits_o
);

   logic [lcg_pkg::COORD_W:0]   sum;
   logic                        diag;
   logic [1:0]                  xc;
   logic [1:0]                  yc;
   logic [lcg_pkg::IDX_W:0]     x_delta;
   logic [lcg_pkg::IDX_W:0]     y_delta;
   logic [lcg_pkg::IDX_W:0]     idx_sum;

   always_comb begin
      sum  = {1'b0, cur_i.num} + {1'b0, line_i.shortest};
      diag = sum >= {1'b0, line_i.longest};
      xc   = diag ? line_i.dirs.diag_x : line_i.dirs.str_x;
      yc   = diag ? line_i.dirs.diag_y : line_i.dirs.str_y;

      nxt_o.num = diag ? lcg_pkg::COORD_W'(sum - {1'b0, line_i.longest})
                       : sum[lcg_pkg::COORD_W-1:0];
      nxt_o.x   = cur_i.x + {{(lcg_pkg::COORD_W-2){xc[1]}}, xc};
      nxt_o.y   = cur_i.y + {{(lcg_pkg::COORD_W-2){yc[1]}}, yc};

      x_delta = {{(lcg_pkg::IDX_W-1){xc[1]}}, xc};
      case (yc)
         lcg_pkg::DIR_POS: y_delta = {{(lcg_pkg::IDX_W-lcg_pkg::COORD_W+1){1'b0}}, row_width_i};
         lcg_pkg::DIR_NEG: y_delta = -{{(lcg_pkg::IDX_W-lcg_pkg::COORD_W+1){1'b0}}, row_width_i};
         default:          y_delta = '0;
      endcase
      idx_sum   = {1'b0, cur_i.idx} + x_delta + y_delta;
      nxt_o.idx = idx_sum[lcg_pkg::IDX_W-1:0];
      fits_o    = lcg_pkg::cell_fits(nxt_o.idx, cells_i);
   end

endmodule

### hw/rtl/bresenham_line_cell_generator.sv
// Top level of the line cell generator: request capture, setup sequencer, walk.
// Depends on lcg_pkg and lcg_step_unit.
//
//   channel  direction  payload
//   req_     in         tdata: start_x, start_y, end_x, end_y, paint_char
//   rsp_     out        tdata: point_x, point_y, cell_index, cell_char; tlast: last_point
//   csr_     in         index (0 row_width, 1 row_count), data
//
// A request passes setup (capture, bound check with buffer size, start index)
// and then the walk gives one point per cycle unless rsp_ stalls, up to 64 points.
// The single step unit sets the point rate; one 6x6 multiplier serves setup.
// req_tready is high only between requests; a stalled rsp_ holds the walk.
// Reset is synchronous: registers return to 63 x 13, the walk goes idle.

module bresenham_line_cell_generator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // start_x, start_y, end_x, end_y, paint_char
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // point_x, point_y, cell_index, cell_char
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [5:0]  csr_data
);

   typedef enum logic [1:0] {ST_IDLE, ST_CHECK, ST_INIT, ST_WALK} state_type;

   localparam int CW = lcg_pkg::COORD_W;
   localparam int IW = lcg_pkg::IDX_W;

   state_type                  state_ff, state_in;
   logic [CW-1:0]              row_width_ff, row_width_in;
   logic [CW-1:0]              row_count_ff, row_count_in;
   logic [IW-1:0]              cells_ff, cells_in;
   logic [lcg_pkg::PT_W-1:0]   sx_ff, sx_in, sy_ff, sy_in, ex_ff, ex_in, ey_ff, ey_in;
   logic [lcg_pkg::CHAR_W-1:0] char_ff, char_in;
   lcg_pkg::line_type          line_ff, line_in;
   lcg_pkg::walk_type          walk_ff, walk_in;
   logic [CW-1:0]              cnt_ff, cnt_in;
   logic                       rsp_tvalid_ff, rsp_tvalid_in;
   logic [31:0]                rsp_tdata_ff, rsp_tdata_in;
   logic                       rsp_tlast_ff, rsp_tlast_in;

   lcg_pkg::walk_type          nxt;
   logic                       nxt_fits;
   logic [CW-1:0]              mul_a;
   logic [IW-1:0]              product;
   logic                       in_bounds;
   logic [CW:0]                w, h;
   logic [CW-1:0]              abs_w, abs_h;
   logic [1:0]                 sgn_w, sgn_h;
   logic                       out_free;
   logic                       last;

   lcg_step_unit u_step (
      .cur_i       (walk_ff),
      .line_i      (line_ff),
      .row_width_i (row_width_ff),
      .cells_i     (cells_ff),
      .nxt_o       (nxt),
      .fits_o      (nxt_fits)
   );

   function automatic logic coord_ok(input logic [lcg_pkg::PT_W-1:0] v,
                                     input logic [CW-1:0] bound);
      return !v[lcg_pkg::PT_W-1] && (v[lcg_pkg::PT_W-2:0] <= {1'b0, bound});
   endfunction

   always_comb begin
      mul_a   = (state_ff == ST_CHECK) ? row_count_ff : walk_ff.y;
      product = IW'(mul_a * row_width_ff);

      in_bounds = coord_ok(sx_ff, row_width_ff) && coord_ok(sy_ff, row_count_ff) &&
                  coord_ok(ex_ff, row_width_ff) && coord_ok(ey_ff, row_count_ff);
      w     = ex_ff[CW:0] - sx_ff[CW:0];
      h     = ey_ff[CW:0] - sy_ff[CW:0];
      abs_w = w[CW] ? CW'(-w) : w[CW-1:0];
      abs_h = h[CW] ? CW'(-h) : h[CW-1:0];
      sgn_w = (w == '0) ? lcg_pkg::DIR_NONE : (w[CW] ? lcg_pkg::DIR_NEG : lcg_pkg::DIR_POS);
      sgn_h = (h == '0) ? lcg_pkg::DIR_NONE : (h[CW] ? lcg_pkg::DIR_NEG : lcg_pkg::DIR_POS);

      out_free = !rsp_tvalid_ff || rsp_tready;
      last     = (cnt_ff == '0) || !nxt_fits;

      state_in      = state_ff;
      row_width_in  = row_width_ff;
      row_count_in  = row_count_ff;
      cells_in      = cells_ff;
      sx_in         = sx_ff;
      sy_in         = sy_ff;
      ex_in         = ex_ff;
      ey_in         = ey_ff;
      char_in       = char_ff;
      line_in       = line_ff;
      walk_in       = walk_ff;
      cnt_in        = cnt_ff;
      rsp_tvalid_in = rsp_tready ? 1'b0 : rsp_tvalid_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tlast_in  = rsp_tlast_ff;

      if (csr_valid) begin
         case (csr_index)
            lcg_pkg::CSR_ROW_WIDTH: row_width_in = csr_data;
            lcg_pkg::CSR_ROW_COUNT: row_count_in = csr_data;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               sx_in    = req_tdata[7:0];
               sy_in    = req_tdata[15:8];
               ex_in    = req_tdata[23:16];
               ey_in    = req_tdata[31:24];
               char_in  = req_tdata[39:32];
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            cells_in          = product;
            line_in.dirs.diag_x = sgn_w;
            line_in.dirs.diag_y = sgn_h;
            if (abs_w > abs_h) begin
               line_in.longest    = abs_w;
               line_in.shortest   = abs_h;
               line_in.dirs.str_x = sgn_w;
               line_in.dirs.str_y = lcg_pkg::DIR_NONE;
            end else begin
               line_in.longest    = abs_h;
               line_in.shortest   = abs_w;
               line_in.dirs.str_x = lcg_pkg::DIR_NONE;
               line_in.dirs.str_y = sgn_h;
            end
            cnt_in      = line_in.longest;
            walk_in.x   = sx_ff[CW-1:0];
            walk_in.y   = sy_ff[CW-1:0];
            walk_in.num = line_in.longest >> 1;
            walk_in.idx = '0;
            state_in    = in_bounds ? ST_INIT : ST_IDLE;
         end
         ST_INIT: begin
            walk_in.idx = product + {{(IW-CW){1'b0}}, walk_ff.x};
            state_in    = lcg_pkg::cell_fits(walk_in.idx, cells_ff) ? ST_WALK : ST_IDLE;
         end
         ST_WALK: begin
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = {char_ff, walk_ff.idx, walk_ff.y, walk_ff.x};
               rsp_tlast_in  = last;
               walk_in       = nxt;
               cnt_in        = cnt_ff - 1'b1;
               if (last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      cells_ff     <= cells_in;
      sx_ff        <= sx_in;
      sy_ff        <= sy_in;
      ex_ff        <= ex_in;
      ey_ff        <= ey_in;
      char_ff      <= char_in;
      line_ff      <= line_in;
      walk_ff      <= walk_in;
      cnt_ff       <= cnt_in;
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tlast_ff <= rsp_tlast_in;
      if (reset) begin
         state_ff      <= ST_IDLE;
         row_width_ff  <= CW'(lcg_pkg::MAX_SIDE);
         row_count_ff  <= CW'(13);
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         row_width_ff  <= row_width_in;
         row_count_ff  <= row_count_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tlast  = rsp_tlast_ff;
   assign csr_ready  = 1'b1;

`ifndef NO_ASSERTIONS
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while a line is in progress");

   a_cell_in_buffer: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> lcg_pkg::cell_fits(rsp_tdata[23:12], cells_ff))
      else $error("cell pair passes buffer end");

   a_row_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[11:6] <= row_count_ff))
      else $error("point row out of range");

   a_hold_while_stalled: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast)))
      else $error("point changed while stalled");
`endif

endmodule
